>>> src/sdft_pkg.sv
// Shared constants, types and ROM builder functions for the segmented DFT bin analyser.
package sdft_pkg;

	localparam int FRAME_LENGTH_DEF = 1024;
	localparam int SAMPLE_W         = 16;
	localparam int MAG_W            = 15;
	localparam int PHASE_W          = 16;
	localparam int SEG_W            = 9;
	localparam int SCALE_W          = 4;
	localparam int MAX_SCALE        = 9;
	localparam int ACC_W            = 42;
	localparam int CORD_W           = 45;
	localparam int ANG_W            = 34;
	localparam int CORD_STEPS       = 16;
	localparam int ITER_W           = 4;
	localparam int ATAN_N           = 30;
	localparam int ATAN_IDX_W       = 5;
	localparam int PROD_W           = 60;
	localparam int K_Q15            = 19898;
	localparam longint K_Q30        = 652032874;

	// arctan(2^-i) as a fraction of a full turn, 2^32 = one turn
	localparam logic [31:0] ATAN_TURN [ATAN_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
		32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
		32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	// controller to datapath commands
	typedef struct packed {
		logic              capture;
		logic              mul1;
		logic              mul2;
		logic              acc;
		logic              cord_step;
		logic [ITER_W-1:0] iter;
		logic              mag_lo;
		logic              mag_hi;
		logic              load_out;
	} sdft_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic seg_end;
	} sdft_sts_t;

	function automatic logic [15:0] clamp15(longint v);
		logic [15:0] r;
		if (v > 32767)
			r = 16'sd32767;
		else if (v < -32767)
			r = -16'sd32767;
		else
			r = v[15:0];
		return r;
	endfunction

	// {cos, sin} of 2*pi*k/2^log2n in Q1.15, by a 30-step rotation CORDIC
	function automatic logic [31:0] twiddle(int k, int log2n);
		longint z;
		longint x;
		longint y;
		longint t;
		logic   flip;
		z    = (longint'(k) << (32 - log2n)) & 64'hFFFF_FFFF;
		x    = K_Q30;
		y    = 0;
		flip = 1'b0;
		if (z >= (longint'(1) << 31))
			z = z - (longint'(1) << 32);
		if (z > (longint'(1) << 30)) begin
			z    = z - (longint'(1) << 31);
			flip = 1'b1;
		end else if (z < -(longint'(1) << 30)) begin
			z    = z + (longint'(1) << 31);
			flip = 1'b1;
		end
		for (int i = 0; i < ATAN_N; i++) begin
			t = x;
			if (z >= 0) begin
				x = x - (y >>> i);
				y = y + (t >>> i);
				z = z - longint'(ATAN_TURN[i]);
			end else begin
				x = x + (y >>> i);
				y = y - (t >>> i);
				z = z + longint'(ATAN_TURN[i]);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		return {clamp15((x + 16384) >>> 15), clamp15((y + 16384) >>> 15)};
	endfunction

endpackage

>>> src/sdft_dp.sv
// Datapath: window and twiddle ROMs, multiply-accumulate, vectoring CORDIC, output register.
module sdft_dp #(
	parameter int LOG2N = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sdft_pkg::sdft_cmd_t                  cmd,
	output sdft_pkg::sdft_sts_t                  sts,
	input  logic [sdft_pkg::SCALE_W-1:0]         scale,
	input  logic signed [sdft_pkg::SAMPLE_W-1:0] sample,
	output logic [sdft_pkg::MAG_W-1:0]           magnitude,
	output logic signed [sdft_pkg::PHASE_W-1:0]  phase,
	output logic [sdft_pkg::SEG_W-1:0]           segment_index,
	output logic                                 last_of_frame
);
	import sdft_pkg::*;

	localparam int N     = 1 << LOG2N;
	localparam int S_LIM = (MAX_SCALE < LOG2N - 1) ? MAX_SCALE : LOG2N - 1;

	typedef logic [31:0] twid_rom_t [N];
	typedef logic [14:0] win_rom_t [N];

	function automatic twid_rom_t build_twid();
		twid_rom_t r;
		for (int k = 0; k < N; k++)
			r[k] = twiddle(k, LOG2N);
		return r;
	endfunction

	function automatic win_rom_t build_win();
		win_rom_t           r;
		logic [31:0]        tw;
		logic signed [16:0] d;
		for (int k = 0; k < N; k++) begin
			tw   = twiddle(k, LOG2N);
			d    = 17'sd32768 - 17'(signed'(tw[31:16]));
			r[k] = d[15:1];
		end
		return r;
	endfunction

	localparam twid_rom_t TWID_ROM = build_twid();
	localparam win_rom_t  WIN_ROM  = build_win();

	// segment geometry from the effective scale
	logic [SCALE_W-1:0] s_eff;
	logic [3:0]         lp;
	logic [LOG2N-1:0]   seg_mask;
	logic [LOG2N-1:0]   m;
	logic [LOG2N-1:0]   idx;
	logic [LOG2N-1:0]   seg_pos;

	logic [LOG2N-1:0]         fp_q;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;

	always_comb begin
		s_eff    = (scale > SCALE_W'(S_LIM)) ? SCALE_W'(S_LIM) : scale;
		lp       = 4'(LOG2N) - 4'(s_eff);
		seg_mask = {LOG2N{1'b1}} >> s_eff;
		m        = fp_q & seg_mask;
		idx      = m << s_eff;
		seg_pos  = fp_q >> lp;
	end

	// capture stage: sample and ROM reads
	logic signed [SAMPLE_W-1:0] smp_q;
	logic [14:0]                win_q;
	logic [31:0]                tw_q;
	logic                       seg_end_q;
	logic [SEG_W-1:0]           seg_idx_q;
	logic                       last_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			smp_q     <= sample;
			win_q     <= WIN_ROM[fp_q];
			tw_q      <= TWID_ROM[idx];
			seg_end_q <= (m == seg_mask);
			seg_idx_q <= SEG_W'(seg_pos);
			last_q    <= &fp_q;
		end
	end

	assign sts.seg_end = seg_end_q;

	// windowing and twiddle products
	logic signed [31:0] wprod_q;
	logic signed [31:0] xw_full;
	logic signed [16:0] xw;
	logic signed [32:0] re_prod_q;
	logic signed [32:0] im_prod_q;

	assign xw_full = (wprod_q + 32'sd16384) >>> 15;
	assign xw      = xw_full[16:0];

	always_ff @(posedge clk) begin
		if (cmd.mul1)
			wprod_q <= smp_q * signed'({1'b0, win_q});
		if (cmd.mul2) begin
			re_prod_q <= xw * signed'(tw_q[31:16]);
			im_prod_q <= xw * signed'(tw_q[15:0]);
		end
	end

	// accumulators, frame position and CORDIC start
	logic signed [ACC_W-1:0]  acc_re_nx;
	logic signed [ACC_W-1:0]  acc_im_nx;
	logic signed [CORD_W-1:0] x0;
	logic signed [CORD_W-1:0] y0;
	logic signed [CORD_W-1:0] cx_q;
	logic signed [CORD_W-1:0] cy_q;
	logic signed [ANG_W-1:0]  cz_q;
	logic                     zero_q;

	assign acc_re_nx = acc_re_q + ACC_W'(re_prod_q);
	assign acc_im_nx = acc_im_q - ACC_W'(im_prod_q);
	assign x0        = CORD_W'(acc_re_nx);
	assign y0        = CORD_W'(acc_im_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q     <= '0;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (cmd.acc) begin
			fp_q <= fp_q + 1'b1;
			if (seg_end_q) begin
				acc_re_q <= '0;
				acc_im_q <= '0;
			end else begin
				acc_re_q <= acc_re_nx;
				acc_im_q <= acc_im_nx;
			end
		end
	end

	// vectoring CORDIC, one step per cycle
	logic signed [CORD_W-1:0] xs;
	logic signed [CORD_W-1:0] ys;
	logic signed [ANG_W-1:0]  ang;

	assign xs  = cx_q >>> cmd.iter;
	assign ys  = cy_q >>> cmd.iter;
	assign ang = signed'({2'b00, ATAN_TURN[{1'b0, cmd.iter}]});

	always_ff @(posedge clk) begin
		if (cmd.acc && seg_end_q) begin
			zero_q <= (acc_re_nx == '0) && (acc_im_nx == '0);
			if (acc_re_nx < 0) begin
				cx_q <= -x0;
				cy_q <= -y0;
				cz_q <= ANG_W'(64'sd2147483648);
			end else begin
				cx_q <= x0;
				cy_q <= y0;
				cz_q <= '0;
			end
		end else if (cmd.cord_step) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + ang;
			end else begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - ang;
			end
		end
	end

	// gain correction, split in two partial products
	logic [CORD_W-1:0] xc;
	logic [PROD_W-1:0] prod_q;

	assign xc = cx_q[CORD_W-1] ? '0 : unsigned'(cx_q);

	always_ff @(posedge clk) begin
		if (cmd.mag_lo)
			prod_q <= PROD_W'(37'(xc[21:0]) * 37'(K_Q15));
		else if (cmd.mag_hi)
			prod_q <= prod_q + (PROD_W'(38'(xc[CORD_W-1:22]) * 38'(K_Q15)) << 22);
	end

	// rounding shift, saturation and output register
	logic [5:0]             sh;
	logic [PROD_W-1:0]      rsum;
	logic [PROD_W-1:0]      q;
	logic signed [ANG_W-1:0] zr;

	always_comb begin
		sh   = 6'd30 + 6'(lp);
		rsum = prod_q + (PROD_W'(1) << (sh - 6'd1));
		q    = rsum >> sh;
		zr   = cz_q + ANG_W'(32768);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (zero_q) begin
				magnitude <= '0;
				phase     <= '0;
			end else begin
				magnitude <= (q > PROD_W'(32767)) ? MAG_W'(32767) : q[MAG_W-1:0];
				phase     <= zr[31:16];
			end
			segment_index <= seg_idx_q;
			last_of_frame <= last_q;
		end
	end

endmodule

>>> src/sdft_ctrl.sv
// Controller: sequences one sample through the datapath and owns the output handshake.
module sdft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output sdft_pkg::sdft_cmd_t cmd,
	input  sdft_pkg::sdft_sts_t sts
);
	import sdft_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL1, S_MUL2, S_ACC, S_CORD, S_MAG_LO, S_MAG_HI, S_EMIT
	} state_t;

	state_t            state_q;
	logic [ITER_W-1:0] iter_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.iter      = iter_q;
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.mul1      = (state_q == S_MUL1);
		cmd.mul2      = (state_q == S_MUL2);
		cmd.acc       = (state_q == S_ACC);
		cmd.cord_step = (state_q == S_CORD);
		cmd.mag_lo    = (state_q == S_MAG_LO);
		cmd.mag_hi    = (state_q == S_MAG_HI);
		cmd.load_out  = (state_q == S_EMIT) && out_free;
	end

	// state, iteration count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new load refills the beat; otherwise it stays until taken
			out_valid_q <= cmd.load_out || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_ACC;
				S_ACC: begin
					iter_q  <= '0;
					state_q <= sts.seg_end ? S_CORD : S_IDLE;
				end
				S_CORD: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ITER_W'(CORD_STEPS - 1))
						state_q <= S_MAG_LO;
				end
				S_MAG_LO: state_q <= S_MAG_HI;
				S_MAG_HI: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> src/segmented_dft_bin_analyzer.sv
// Segmented single-bin DFT analyser, top level.
//
// Input channel: one signed 16-bit sample per beat (in_valid / in_stall), in
// frame order. Each sample is Hann-windowed and rotated by the segment twiddle,
// then added into complex accumulators. The frame of 2^log2(FRAME_LENGTH)
// samples is cut into 2^scale segments (scale clipped to 9 and to log2(N)-1).
// Output channel: one beat per segment end (out_valid / out_stall) carrying
// magnitude / P, phase in pi/32768 units, segment index and a last-of-frame flag.
// Sequence: a sample passes through ROM read, window multiply, twiddle multiply
// and accumulate. A segment-ending sample adds 16 CORDIC iterations, the two
// partial-product steps and the output load, which waits while a pending beat
// is stalled; the next sample is taken only after that. The single shared CORDIC
// and the sample loop bound the sample rate. A finished beat sits in the output
// register; the next samples are accepted while it waits, and only the next
// segment result waits for it to be taken. Reset clears frame position,
// accumulators, scale and the output valid flag. The user must write scale via
// cfg_we / cfg_wdata while the block is idle; the block does not enforce this.
module segmented_dft_bin_analyzer #(
	parameter int FRAME_LENGTH = sdft_pkg::FRAME_LENGTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [sdft_pkg::SCALE_W-1:0]         cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [sdft_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sdft_pkg::MAG_W-1:0]           magnitude,
	output logic signed [sdft_pkg::PHASE_W-1:0]  phase,
	output logic [sdft_pkg::SEG_W-1:0]           segment_index,
	output logic                                 last_of_frame
);
	import sdft_pkg::*;

	localparam int LOG2N = $clog2(FRAME_LENGTH + 1) - 1;

	logic [SCALE_W-1:0] scale_q;
	sdft_cmd_t          cmd;
	sdft_sts_t          sts;

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			scale_q <= '0;
		else if (cfg_we)
			scale_q <= cfg_wdata;
	end

	sdft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	sdft_dp #(
		.LOG2N (LOG2N)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.scale         (scale_q),
		.sample        (sample),
		.magnitude     (magnitude),
		.phase         (phase),
		.segment_index (segment_index),
		.last_of_frame (last_of_frame)
	);

`ifndef SYNTH
	// an accepted beat keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepted beat");

	// a result is never loaded over a beat that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid && out_stall))
		else $error("output overwritten while stalled");

	// out_valid only rises after a load command
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("out_valid rose without load");
`endif

endmodule
